### rtl/core/tsvc_pkg.sv
// Package: shared types and constants of the timed sweep valve controller.
package tsvc_pkg;

   localparam int unsigned TIME_W  = 32;
   localparam int unsigned ANGLE_W = 8;
   localparam int unsigned MODE_W  = 2;
   localparam int unsigned PHASE_W = 2;
   localparam int unsigned CSR_AW  = 3;
   localparam int unsigned CSR_DW  = 32;

   localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;

   localparam logic [TIME_W-1:0] OPEN_TIME_RST   = 32'd5000;
   localparam logic [TIME_W-1:0] CLOSED_TIME_RST = 32'd10000;

   // System modes
   localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd1;
   localparam logic [MODE_W-1:0] MODE_ALARM  = 2'd2;

   // Register indexes (byte address = 4 * index)
   localparam logic REG_OPEN_TIME   = 1'b0;
   localparam logic REG_CLOSED_TIME = 1'b1;

   typedef enum logic [PHASE_W-1:0] {
      PH_READY  = 2'd0,
      PH_OPEN   = 2'd1,
      PH_CLOSED = 2'd2
   } phase_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] angle;
      logic               down;
   } sweep_type;

endpackage

### rtl/core/tsvc_if.sv
// Interfaces: tick request channel and result channel.
interface tsvc_req_if
   import tsvc_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [TIME_W-1:0]  now_ms;
   logic [MODE_W-1:0]  mode;
   logic               open_request;
   logic               close_request;
   logic [ANGLE_W-1:0] sweep_speed;

   modport source (
      output valid, now_ms, mode, open_request, close_request, sweep_speed,
      input  ready
   );
   modport sink (
      input  valid, now_ms, mode, open_request, close_request, sweep_speed,
      output ready
   );
endinterface

interface tsvc_rsp_if
   import tsvc_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [PHASE_W-1:0] ctrl_state;
   logic [ANGLE_W-1:0] servo_angle;
   logic               angle_written;
   logic               open_taken;
   logic               close_taken;

   modport source (
      output valid, ctrl_state, servo_angle, angle_written, open_taken, close_taken,
      input  ready
   );
   modport sink (
      input  valid, ctrl_state, servo_angle, angle_written, open_taken, close_taken,
      output ready
   );
endinterface

### rtl/core/timed_sweep_valve_controller.sv
// Top level: tick-driven valve state machine with servo sweep and APB timers.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------------------------
//   req     | in        | valid/ready           | now_ms, mode, open/close req, speed
//   rsp     | out       | valid/ready           | ctrl_state, servo_angle, flags
//   csr     | in        | APB psel/penable      | open_time_ms @0x0, closed_time_ms @0x4
//
// One tick item per cycle while the result register can be drained: the item is evaluated
// in the cycle it is accepted and its result lands in the output register on that edge.
// A tick's state update is 32-bit subtracts and compares plus the sweep add or subtract.
// req.ready stays high while the output register is empty or being drained,
// so a stalled result holds only the input side, never loses an item.
// Synchronous active-high reset: phase ready, angle 0 sweeping up, time marks 0,
// timers 5000 / 10000 ms.
module timed_sweep_valve_controller
   import tsvc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   tsvc_req_if.sink          req_port,
   tsvc_rsp_if.source        rsp_port,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   // configuration
   logic [TIME_W-1:0] open_time_ff, closed_time_ff;
   logic              csr_wr;

   // controller state
   phase_type         phase_ff, phase_in;
   sweep_type         sweep_ff, sweep_in, sweep_step;
   logic [TIME_W-1:0] opened_at_ff, opened_at_in;
   logic [TIME_W-1:0] closed_at_ff, closed_at_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PHASE_W-1:0] rsp_state_ff, rsp_state_in;
   logic [ANGLE_W-1:0] rsp_angle_ff, rsp_angle_in;
   logic               rsp_wrote_ff, rsp_wrote_in;
   logic               rsp_otaken_ff, rsp_otaken_in;
   logic               rsp_ctaken_ff, rsp_ctaken_in;

   logic              accept;
   logic [TIME_W-1:0] open_elapsed, closed_elapsed;
   logic              do_sweep;

   // ---------------- APB register file ----------------
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == REG_CLOSED_TIME) ? closed_time_ff : open_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_time_ff   <= OPEN_TIME_RST;
         closed_time_ff <= CLOSED_TIME_RST;
      end else if (csr_wr) begin
         if (paddr[2] == REG_OPEN_TIME) begin
            open_time_ff <= pwdata;
         end else begin
            closed_time_ff <= pwdata;
         end
      end
   end

   // ---------------- handshake ----------------
   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign accept         = req_port.valid && req_port.ready;

   // elapsed times wrap modulo 2^32
   assign open_elapsed   = req_port.now_ms - opened_at_ff;
   assign closed_elapsed = req_port.now_ms - closed_at_ff;

   tsvc_sweep u_sweep (
      .cur   (sweep_ff),
      .speed (req_port.sweep_speed),
      .nxt   (sweep_step)
   );

   // ---------------- tick evaluation ----------------
   always_comb begin
      phase_in      = phase_ff;
      sweep_in      = sweep_ff;
      opened_at_in  = opened_at_ff;
      closed_at_in  = closed_at_ff;
      rsp_otaken_in = 1'b0;
      rsp_ctaken_in = 1'b0;
      do_sweep      = 1'b0;

      case (phase_ff)
         PH_READY: begin
            // alarm and the unused mode code never open
            if ((req_port.mode == MODE_AUTO || req_port.mode == MODE_MANUAL)
                && req_port.open_request) begin
               rsp_otaken_in = 1'b1;
               opened_at_in  = req_port.now_ms;
               phase_in      = PH_OPEN;
            end
         end
         PH_OPEN: begin
            do_sweep = 1'b1;
            if (req_port.mode == MODE_ALARM) begin
               closed_at_in = req_port.now_ms;
               phase_in     = PH_CLOSED;
               do_sweep     = 1'b0;
            end else if (req_port.mode == MODE_MANUAL) begin
               // manual close still sweeps this tick
               if (req_port.close_request) begin
                  rsp_ctaken_in = 1'b1;
                  closed_at_in  = req_port.now_ms;
                  phase_in      = PH_CLOSED;
               end
            end else if (req_port.mode == MODE_AUTO) begin
               if (open_elapsed > open_time_ff) begin
                  closed_at_in = req_port.now_ms;
                  phase_in     = PH_CLOSED;
                  do_sweep     = 1'b0;
               end
            end
         end
         PH_CLOSED: begin
            // reopen in any mode
            if (req_port.open_request) begin
               rsp_otaken_in = 1'b1;
               opened_at_in  = req_port.now_ms;
               phase_in      = PH_OPEN;
            end else if (closed_elapsed > closed_time_ff) begin
               phase_in = PH_READY;
            end
         end
         default: begin
            phase_in = PH_READY;
         end
      endcase

      if (do_sweep) begin
         sweep_in = sweep_step;
      end

      rsp_state_in = phase_in;
      rsp_angle_in = sweep_in.angle;
      rsp_wrote_in = do_sweep;
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_port.ready);
   end

   // ---------------- state registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_READY;
         sweep_ff     <= '0;
         opened_at_ff <= '0;
         closed_at_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff     <= phase_in;
            sweep_ff     <= sweep_in;
            opened_at_ff <= opened_at_in;
            closed_at_ff <= closed_at_in;
         end
      end
   end

   // result payload, loaded only with an accepted item
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_state_ff  <= rsp_state_in;
         rsp_angle_ff  <= rsp_angle_in;
         rsp_wrote_ff  <= rsp_wrote_in;
         rsp_otaken_ff <= rsp_otaken_in;
         rsp_ctaken_ff <= rsp_ctaken_in;
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.ctrl_state    = rsp_state_ff;
   assign rsp_port.servo_angle   = rsp_angle_ff;
   assign rsp_port.angle_written = rsp_wrote_ff;
   assign rsp_port.open_taken    = rsp_otaken_ff;
   assign rsp_port.close_taken   = rsp_ctaken_ff;

endmodule

### rtl/core/tsvc_sweep.sv
// Sweep unit: one bounce step of the servo angle between 0 and 180.
module tsvc_sweep
   import tsvc_pkg::*;
(
   input  sweep_type          cur,
   input  logic [ANGLE_W-1:0] speed,
   output sweep_type          nxt
);

   logic [ANGLE_W:0] sum;

   assign sum = {1'b0, cur.angle} + {1'b0, speed};

   always_comb begin
      nxt = cur;
      if (!cur.down) begin
         if (sum > {1'b0, ANGLE_MAX}) begin
            nxt.angle = ANGLE_MAX;
            nxt.down  = 1'b1;
         end else begin
            nxt.angle = sum[ANGLE_W-1:0];
         end
      end else begin
         if (speed > cur.angle) begin
            nxt.angle = '0;
            nxt.down  = 1'b0;
         end else begin
            nxt.angle = cur.angle - speed;
         end
      end
   end

endmodule

### tb/tb_top.sv
// Testbench top: directed and random ticks for the valve controller, checked by a predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tsvc_pkg::*;

   // Mode code 3 has no name in the package; the block treats it as "neither"
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned LONG_STALL  = 200;   // receiver hold-off, in cycles
   localparam int unsigned MAX_REPORTS = 40;    // mismatch lines printed, all are counted

   typedef struct packed {
      logic [TIME_W-1:0]  now_ms;
      logic [MODE_W-1:0]  mode;
      logic               open_request;
      logic               close_request;
      logic [ANGLE_W-1:0] sweep_speed;
   } tick_type;

   typedef struct packed {
      phase_type          ctrl_state;
      logic [ANGLE_W-1:0] servo_angle;
      logic               angle_written;
      logic               open_taken;
      logic               close_taken;
   } valve_result_type;

   // ---------------------------------------------------------------------
   // Clock, reset, DUT
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset;

   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   tsvc_req_if req_if ();
   tsvc_rsp_if rsp_if ();

   always #1 clock = ~clock;

   timed_sweep_valve_controller dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // ---------------------------------------------------------------------
   // Predictor state: a private copy of the valve, its servo and its timers
   // ---------------------------------------------------------------------
   phase_type          valve_phase   = PH_READY;
   logic [ANGLE_W-1:0] valve_angle   = '0;
   logic               sweeping_down = 1'b0;
   logic [TIME_W-1:0]  opened_stamp  = '0;
   logic [TIME_W-1:0]  closed_stamp  = '0;
   logic [TIME_W-1:0]  open_limit    = OPEN_TIME_RST;
   logic [TIME_W-1:0]  closed_limit  = CLOSED_TIME_RST;

   valve_result_type awaited_results[$];   // oldest first, one per accepted tick
   valve_result_type oldest;

   int          error_count     = 0;
   int          results_checked = 0;
   int          ticks_sent      = 0;
   int          timer_writes    = 0;
   int unsigned cycle_count     = 0;
   bit          jitter_on       = 1'b1;  // random idling on both channels
   int unsigned stall_request   = 0;     // nonzero: receiver holds off this many cycles
   logic [TIME_W-1:0] wall_ms   = '0;    // running time base for random ticks

   // Advance the predicted valve by one tick and return what the block must report.
   function automatic valve_result_type predict_tick(input tick_type t);
      valve_result_type  r;
      logic              swing;
      logic [TIME_W-1:0] elapsed;
      logic [ANGLE_W:0]  sum;
      r.angle_written = 1'b0;
      r.open_taken    = 1'b0;
      r.close_taken   = 1'b0;
      case (valve_phase)
         PH_READY: begin
            if ((t.mode == MODE_AUTO || t.mode == MODE_MANUAL) && t.open_request) begin
               r.open_taken = 1'b1;
               opened_stamp = t.now_ms;
               valve_phase  = PH_OPEN;
            end
         end
         PH_OPEN: begin
            swing = 1'b1;
            elapsed = t.now_ms - opened_stamp;
            if (t.mode == MODE_ALARM) begin
               closed_stamp = t.now_ms;
               valve_phase  = PH_CLOSED;
               swing        = 1'b0;
            end else if (t.mode == MODE_MANUAL) begin
               // manual close still sweeps in the same tick
               if (t.close_request) begin
                  r.close_taken = 1'b1;
                  closed_stamp  = t.now_ms;
                  valve_phase   = PH_CLOSED;
               end
            end else if (t.mode == MODE_AUTO) begin
               if (elapsed > open_limit) begin
                  closed_stamp = t.now_ms;
                  valve_phase  = PH_CLOSED;
                  swing        = 1'b0;
               end
            end
            if (swing) begin
               r.angle_written = 1'b1;
               if (!sweeping_down) begin
                  sum = {1'b0, valve_angle} + {1'b0, t.sweep_speed};
                  if (sum > {1'b0, ANGLE_MAX}) begin
                     valve_angle   = ANGLE_MAX;
                     sweeping_down = 1'b1;
                  end else
                     valve_angle = sum[ANGLE_W-1:0];
               end else if (t.sweep_speed > valve_angle) begin
                  valve_angle   = '0;
                  sweeping_down = 1'b0;
               end else
                  valve_angle = valve_angle - t.sweep_speed;
            end
         end
         PH_CLOSED: begin
            elapsed = t.now_ms - closed_stamp;
            if (t.open_request) begin
               r.open_taken = 1'b1;
               opened_stamp = t.now_ms;
               valve_phase  = PH_OPEN;
            end else if (elapsed > closed_limit)
               valve_phase = PH_READY;
         end
         default: ;
      endcase
      r.ctrl_state  = valve_phase;
      r.servo_angle = valve_angle;
      return r;
   endfunction

   function automatic tick_type make_tick(input logic [TIME_W-1:0] now,
                                          input logic [MODE_W-1:0] mode,
                                          input logic oreq, input logic creq,
                                          input logic [ANGLE_W-1:0] speed);
      tick_type t;
      t.now_ms        = now;
      t.mode          = mode;
      t.open_request  = oreq;
      t.close_request = creq;
      t.sweep_speed   = speed;
      return t;
   endfunction

   // Random tick: time mostly creeps forward by small steps, sometimes jumps anywhere.
   function automatic tick_type random_tick(input int unsigned step_max,
                                            input int unsigned alarm_pct);
      tick_type    t;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 3)
         wall_ms = $urandom();
      else
         wall_ms = wall_ms + $urandom_range(0, step_max);
      t.now_ms = wall_ms;
      pick = $urandom_range(0, 99);
      if (pick < alarm_pct)
         t.mode = MODE_ALARM;
      else if (pick < alarm_pct + 3)
         t.mode = MODE_SPARE;
      else if (pick < alarm_pct + 3 + (97 - alarm_pct) * 55 / 100)
         t.mode = MODE_AUTO;
      else
         t.mode = MODE_MANUAL;
      t.open_request  = ($urandom_range(0, 99) < 30);
      t.close_request = ($urandom_range(0, 99) < 30);
      if ($urandom_range(0, 9) == 0)
         t.sweep_speed = ANGLE_W'($urandom_range(181, 255));   // overshoot beyond the 0..180 angle range
      else
         t.sweep_speed = ANGLE_W'($urandom_range(0, 180));
      return t;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("MISMATCH result %0d %s: got %0d expected %0d", results_checked, what, got,
                  want);
   endtask

   // ---------------------------------------------------------------------
   // Tick channel: hold the item until the block takes it, then predict
   // ---------------------------------------------------------------------
   task automatic send_tick(input tick_type t);
      req_if.valid         <= 1'b1;
      req_if.now_ms        <= t.now_ms;
      req_if.mode          <= t.mode;
      req_if.open_request  <= t.open_request;
      req_if.close_request <= t.close_request;
      req_if.sweep_speed   <= t.sweep_speed;
      do @(posedge clock); while (!req_if.ready);
      awaited_results.push_back(predict_tick(t));
      ticks_sent++;
      if (jitter_on && $urandom_range(0, 7) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic run_ticks(input int count, input int unsigned step_max,
                            input int unsigned alarm_pct);
      for (int i = 0; i < count; i++)
         send_tick(random_tick(step_max, alarm_pct));
   endtask

   // Sender goes quiet until every predicted result has come back.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (awaited_results.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Timer registers over APB; register index i sits at byte address 4*i
   // ---------------------------------------------------------------------
   task automatic csr_access(input logic idx, input logic wr, input logic [CSR_DW-1:0] wdata,
                             output logic [CSR_DW-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;   // sampled in the access phase
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_timer(input logic idx, input logic [CSR_DW-1:0] want);
      logic [CSR_DW-1:0] value;
      csr_access(idx, 1'b0, '0, value);
      if (value !== want)
         report_mismatch(idx == REG_OPEN_TIME ? "open_time_ms readback" :
                         "closed_time_ms readback", value, want);
   endtask

   // Write one timer while the block is idle, mirror it, read it back.
   task automatic program_timer(input logic idx, input logic [CSR_DW-1:0] value);
      logic [CSR_DW-1:0] unused;
      wait_drained();
      csr_access(idx, 1'b1, value, unused);
      if (idx == REG_OPEN_TIME)
         open_limit = value;
      else
         closed_limit = value;
      timer_writes++;
      check_timer(idx, value);
   endtask

   task automatic program_timers(input logic [CSR_DW-1:0] open_ms,
                                 input logic [CSR_DW-1:0] closed_ms);
      program_timer(REG_OPEN_TIME, open_ms);
      program_timer(REG_CLOSED_TIME, closed_ms);
   endtask

   // ---------------------------------------------------------------------
   // Result channel: random stalls, plus the long hold-off on request
   // ---------------------------------------------------------------------
   initial begin : result_drain
      int unsigned held;
      int unsigned burst;
      rsp_if.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (stall_request != 0) begin
            rsp_if.ready <= 1'b0;
            for (held = 0; held < stall_request; held++)
               @(posedge clock);
            stall_request = 0;
            rsp_if.ready <= 1'b1;
         end else if (jitter_on && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 10);
            rsp_if.ready <= 1'b0;
            repeat (burst) @(posedge clock);
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Each accepted result is compared with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (awaited_results.size() == 0)
            report_mismatch("result with no tick outstanding", 32'(rsp_if.ctrl_state), 0);
         else begin
            oldest = awaited_results.pop_front();
            if (rsp_if.ctrl_state !== oldest.ctrl_state)
               report_mismatch("ctrl_state", 32'(rsp_if.ctrl_state), 32'(oldest.ctrl_state));
            if (rsp_if.servo_angle !== oldest.servo_angle)
               report_mismatch("servo_angle", 32'(rsp_if.servo_angle),
                               32'(oldest.servo_angle));
            if (rsp_if.angle_written !== oldest.angle_written)
               report_mismatch("angle_written", 32'(rsp_if.angle_written),
                               32'(oldest.angle_written));
            if (rsp_if.open_taken !== oldest.open_taken)
               report_mismatch("open_taken", 32'(rsp_if.open_taken), 32'(oldest.open_taken));
            if (rsp_if.close_taken !== oldest.close_taken)
               report_mismatch("close_taken", 32'(rsp_if.close_taken),
                               32'(oldest.close_taken));
         end
         results_checked++;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Timers must come out of reset at 5000 / 10000 ms.
   task automatic test_reset_values();
      check_timer(REG_OPEN_TIME, OPEN_TIME_RST);
      check_timer(REG_CLOSED_TIME, CLOSED_TIME_RST);
   endtask

   // Hand-picked walk through every transition with short timers (open 10, closed 20).
   task automatic test_directed();
      program_timers(32'd10, 32'd20);
      send_tick(make_tick(32'd100, MODE_ALARM, 1'b1, 1'b0, 8'd10));   // alarm blocks open
      send_tick(make_tick(32'd101, MODE_SPARE, 1'b1, 1'b1, 8'd10));   // spare mode opens nothing
      send_tick(make_tick(32'd102, MODE_AUTO, 1'b0, 1'b1, 8'd10));    // no request, stay ready
      send_tick(make_tick(32'hFFFF_FFF8, MODE_MANUAL, 1'b1, 1'b1, 8'd0)); // open just before wrap
      send_tick(make_tick(32'hFFFF_FFFF, MODE_SPARE, 1'b1, 1'b1, 8'd255)); // spare: sweep only
      send_tick(make_tick(32'd2, MODE_AUTO, 1'b0, 1'b1, 8'd0));       // elapsed == open time
      send_tick(make_tick(32'd2, MODE_AUTO, 1'b0, 1'b0, 8'd180));     // down to exactly 0
      send_tick(make_tick(32'd2, MODE_AUTO, 1'b0, 1'b0, 8'd1));       // bounce off 0
      send_tick(make_tick(32'd3, MODE_AUTO, 1'b0, 1'b0, 8'd7));       // auto timeout, no sweep
      send_tick(make_tick(32'd23, MODE_ALARM, 1'b0, 1'b1, 8'd5));     // elapsed == closed time
      send_tick(make_tick(32'd23, MODE_SPARE, 1'b1, 1'b0, 8'd5));     // reopen in any mode
      send_tick(make_tick(32'd24, MODE_MANUAL, 1'b0, 1'b0, 8'd100));  // manual, no close
      send_tick(make_tick(32'd30, MODE_MANUAL, 1'b1, 1'b1, 8'd100));  // manual close + sweep
      send_tick(make_tick(32'd51, MODE_AUTO, 1'b0, 1'b0, 8'd0));      // closed timeout
      send_tick(make_tick(32'd60, MODE_AUTO, 1'b1, 1'b0, 8'd0));
      send_tick(make_tick(32'd60, MODE_ALARM, 1'b1, 1'b1, 8'd50));    // alarm close, no sweep
      send_tick(make_tick(32'd61, MODE_MANUAL, 1'b1, 1'b1, 8'd50));
      send_tick(make_tick(32'd62, MODE_AUTO, 1'b0, 1'b0, 8'd181));    // overshoot below 0
      send_tick(make_tick(32'd63, MODE_AUTO, 1'b0, 1'b0, 8'd180));    // land on 180 going up
      send_tick(make_tick(32'd64, MODE_AUTO, 1'b0, 1'b0, 8'd1));      // turn at the top
      send_tick(make_tick(32'd0, MODE_ALARM, 1'b0, 1'b0, 8'd0));
      send_tick(make_tick(32'd21, MODE_AUTO, 1'b0, 1'b0, 8'd0));
   endtask

   // Short timers with time wrapping through zero early on.
   task automatic test_mid_timers();
      program_timers(32'd25, 32'd60);
      wall_ms = 32'hFFFF_FF00;
      run_ticks(350, 8, 10);
   endtask

   // Zero and all-ones limits, alone and mixed.
   task automatic test_extreme_timers();
      program_timers(32'd0, 32'd0);
      run_ticks(130, 3, 5);
      program_timers(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      run_ticks(130, 50000, 10);
      program_timers(32'hFFFF_FFFF, 32'd0);
      run_ticks(70, 4, 10);
      program_timers(32'd0, 32'hFFFF_FFFF);
      run_ticks(70, 4, 6);
   endtask

   task automatic test_reset_timers();
      program_timers(OPEN_TIME_RST, CLOSED_TIME_RST);
      run_ticks(300, 1500, 8);
   endtask

   // Long receiver hold-off fills the block; later the sender waits for a full drain.
   task automatic test_backpressure();
      program_timers(32'd30, 32'd45);
      run_ticks(60, 6, 8);
      stall_request = LONG_STALL;
      run_ticks(100, 6, 8);
      wait_drained();
      run_ticks(140, 6, 8);
   endtask

   // No idling on either side: back-to-back ticks.
   task automatic test_full_rate();
      jitter_on = 1'b0;
      program_timers($urandom_range(1, 40), $urandom_range(1, 80));
      run_ticks(580, 8, 8);
   endtask

   initial begin
      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.now_ms        <= '0;
      req_if.mode          <= MODE_AUTO;
      req_if.open_request  <= 1'b0;
      req_if.close_request <= 1'b0;
      req_if.sweep_speed   <= '0;
      psel                 <= 1'b0;
      penable              <= 1'b0;
      pwrite               <= 1'b0;
      paddr                <= '0;
      pwdata               <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_directed();
      test_mid_timers();
      test_extreme_timers();
      test_reset_timers();
      test_backpressure();
      test_full_rate();

      wait_drained();
      repeat (5) @(posedge clock);
      $display("Sent %0d ticks, checked %0d results over %0d timer writes", ticks_sent,
               results_checked, timer_writes);
      $display("Covered all modes, timeouts at and past the limit, wrapped time, overshoot");
      if (error_count == 0 && awaited_results.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
